[rtl/core/lcr_pkg.sv]
package lcr_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = ADDR_W + 1;
  localparam int KEY_W         = 32;
  localparam int LEN_W         = 9;
  localparam int ROW_W         = KEY_W + LEN_W;

  localparam logic [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN1,
    ST_SCAN2,
    ST_WR_LO,
    ST_WR_HI,
    ST_WR_NEW,
    ST_DONE
  } lcr_state_e;

endpackage

[rtl/core/lcr_ram.sv]
module lcr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/core/longest_consecutive_run_tracker_core.sv]
// Longest consecutive run tracker. A request (value_i, last_i) is taken when
// start_i is high and busy_o is low; exactly one result follows, shown on
// longest_o / overflow_o for one cycle with result_valid_o high, and it must
// be captured then because the block cannot be stalled. Entries live packed
// in one single-port-read table RAM filled in arrival order, so every lookup
// is a linear scan of the stored entries, one row per cycle through the RAM
// read port. A duplicate, or a request that meets a full table, ends after
// the first scan; a value with no neighbor also writes its own row, and one
// that joins one or two existing runs first adds a second scan and a rewrite
// of each far end of those runs. The result strobe comes in the first cycle after
// busy_o falls. The table is emptied at once after the request marked last,
// by resetting the fill count; no clearing pass is needed.
module longest_consecutive_run_tracker_core
  import lcr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [KEY_W-1:0] value_i,
  input  logic             last_i,
  output logic             result_valid_o,
  output logic [LEN_W-1:0] longest_o,
  output logic             overflow_o
);

  lcr_state_e state_q, state_d;

  logic [KEY_W-1:0]  val_q;
  logic              last_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic              rvld_q, rvld_d;
  logic [ADDR_W-1:0] ridx_q;
  logic              dup_q, dup_d;
  logic              lo_f_q, lo_f_d, hi_f_q, hi_f_d;
  logic [LEN_W-1:0]  lo_len_q, lo_len_d, hi_len_q, hi_len_d;
  logic [ADDR_W-1:0] a_idx_q, a_idx_d, b_idx_q, b_idx_d;
  logic [LEN_W-1:0]  best_q, best_d;
  logic              ovf_q, ovf_d;
  logic              res_vld_q;
  logic [LEN_W-1:0]  res_len_q;
  logic              res_ovf_q;

  logic              issue;
  logic              scan_end;
  logic              tbl_full;
  logic [KEY_W-1:0]  ka, kb;
  logic [LEN_W-1:0]  n_len;
  logic              accept;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  ram_rdata;
  logic [KEY_W-1:0]  rkey;
  logic [LEN_W-1:0]  rlen;

  lcr_ram #(
    .Width (ROW_W),
    .Depth (TABLE_ENTRIES)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // scan control and shared terms
  assign accept   = start_i && (state_q == ST_IDLE);
  assign busy_o   = (state_q != ST_IDLE);
  assign issue    = (ptr_q < count_q);
  assign scan_end = !issue && !rvld_q;
  assign tbl_full = (count_q == CNT_W'(TABLE_ENTRIES));
  assign rkey     = ram_rdata[ROW_W-1:LEN_W];
  assign rlen     = ram_rdata[LEN_W-1:0];
  assign ka       = val_q - KEY_W'(lo_len_q);
  assign kb       = val_q + KEY_W'(hi_len_q);
  assign n_len    = lo_len_q + hi_len_q + LEN_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SCAN1;
      end
      ST_SCAN1: begin
        if (scan_end) begin
          if (dup_q || tbl_full) state_d = ST_DONE;
          else if (lo_f_q || hi_f_q) state_d = ST_SCAN2;
          else state_d = ST_WR_NEW;
        end
      end
      ST_SCAN2: begin
        if (scan_end) state_d = lo_f_q ? ST_WR_LO : ST_WR_HI;
      end
      ST_WR_LO:  state_d = hi_f_q ? ST_WR_HI : ST_WR_NEW;
      ST_WR_HI:  state_d = ST_WR_NEW;
      ST_WR_NEW: state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and table controls
  always_comb begin
    count_d   = count_q;
    ptr_d     = ptr_q;
    rvld_d    = 1'b0;
    dup_d     = dup_q;
    lo_f_d    = lo_f_q;
    hi_f_d    = hi_f_q;
    lo_len_d  = lo_len_q;
    hi_len_d  = hi_len_q;
    a_idx_d   = a_idx_q;
    b_idx_d   = b_idx_q;
    best_d    = best_q;
    ovf_d     = ovf_q;
    ram_we    = 1'b0;
    ram_waddr = count_q[ADDR_W-1:0];
    ram_wdata = {val_q, n_len};
    unique case (state_q)
      ST_IDLE: begin
        ptr_d    = '0;
        dup_d    = 1'b0;
        lo_f_d   = 1'b0;
        hi_f_d   = 1'b0;
        lo_len_d = '0;
        hi_len_d = '0;
      end
      ST_SCAN1: begin
        if (issue) ptr_d = ptr_q + CNT_W'(1);
        rvld_d = issue;
        // one row against the value and both neighbors
        if (rvld_q) begin
          if (rkey == val_q) dup_d = 1'b1;
          if ((rkey == val_q - KEY_W'(1)) && (val_q != KEY_MIN)) begin
            lo_f_d   = 1'b1;
            lo_len_d = rlen;
          end
          if ((rkey == val_q + KEY_W'(1)) && (val_q != KEY_MAX)) begin
            hi_f_d   = 1'b1;
            hi_len_d = rlen;
          end
        end
        if (scan_end) begin
          ptr_d = '0;
          if (!dup_q && tbl_full) ovf_d = 1'b1;
        end
      end
      ST_SCAN2: begin
        if (issue) ptr_d = ptr_q + CNT_W'(1);
        rvld_d = issue;
        // locate the far ends of the neighbor runs
        if (rvld_q) begin
          if (rkey == ka) a_idx_d = ridx_q;
          if (rkey == kb) b_idx_d = ridx_q;
        end
      end
      ST_WR_LO: begin
        ram_we    = 1'b1;
        ram_waddr = a_idx_q;
        ram_wdata = {ka, n_len};
      end
      ST_WR_HI: begin
        ram_we    = 1'b1;
        ram_waddr = b_idx_q;
        ram_wdata = {kb, n_len};
      end
      ST_WR_NEW: begin
        ram_we  = 1'b1;
        count_d = count_q + CNT_W'(1);
        if (n_len > best_q) best_d = n_len;
      end
      ST_DONE: begin
        // end of set empties the table
        if (last_q) begin
          count_d = '0;
          best_d  = '0;
          ovf_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      ptr_q     <= '0;
      rvld_q    <= 1'b0;
      best_q    <= '0;
      ovf_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      rvld_q    <= rvld_d;
      best_q    <= best_d;
      ovf_q     <= ovf_d;
      res_vld_q <= (state_q == ST_DONE);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q  <= value_i;
      last_q <= last_i;
    end
    ridx_q   <= ptr_q[ADDR_W-1:0];
    dup_q    <= dup_d;
    lo_f_q   <= lo_f_d;
    hi_f_q   <= hi_f_d;
    lo_len_q <= lo_len_d;
    hi_len_q <= hi_len_d;
    a_idx_q  <= a_idx_d;
    b_idx_q  <= b_idx_d;
    if (state_q == ST_DONE) begin
      res_len_q <= best_q;
      res_ovf_q <= ovf_q;
    end
  end

  assign result_valid_o = res_vld_q;
  assign longest_o      = res_len_q;
  assign overflow_o     = res_ovf_q;

`ifndef ASSERT_OFF
  a_one_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");
  a_no_insert_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR_NEW) |-> !tbl_full)
    else $error("insert into full table");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o && !result_valid_o)
    else $error("request not held busy");
`endif

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import lcr_pkg::*;

  localparam int HALF_PERIOD    = 6;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 600;
  localparam int RANDOM_ITEMS   = 675;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic [KEY_W-1:0] value_i = '0;
  logic             last_i = 1'b0;
  logic             result_valid_o;
  logic [LEN_W-1:0] longest_o;
  logic             overflow_o;

  typedef struct packed {
    logic [LEN_W-1:0] longest;
    logic             overflow;
  } run_result_t;

  // Directed stimulus row; check_exact means the typed-in result is compared too
  typedef struct {
    logic [KEY_W-1:0] value;
    logic             last;
    logic             check_exact;
    logic [LEN_W-1:0] longest;
    logic             overflow;
  } stim_row_t;

  // Predictor state
  logic [KEY_W-1:0] run_keys[$];
  int unsigned      run_lens[$];
  int unsigned      best_run;
  logic             drop_seen;

  run_result_t pending_results[$];
  run_result_t typed_results[$];
  logic        typed_flags[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          timed_out = 1'b0;
  bit          calm_mode = 1'b0;

  longest_consecutive_run_tracker_core DUT (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .value_i,
    .last_i,
    .result_valid_o,
    .longest_o,
    .overflow_o
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic int find_key(input logic [KEY_W-1:0] key);
    for (int i = 0; i < run_keys.size(); i++) begin
      if (run_keys[i] == key) return i;
    end
    return -1;
  endfunction

  // Merge one value into the run table and return the resulting output
  function automatic run_result_t merge_value(input logic [KEY_W-1:0] val,
                                              input logic last);
    run_result_t r;
    int lo, hi, e;
    int unsigned l1, l2, n;
    if (find_key(val) < 0) begin
      if (run_keys.size() >= TABLE_ENTRIES) begin
        drop_seen = 1'b1;
      end else begin
        lo = (val != KEY_MIN) ? find_key(val - 1) : -1;
        hi = (val != KEY_MAX) ? find_key(val + 1) : -1;
        l1 = (lo >= 0) ? run_lens[lo] : 0;
        l2 = (hi >= 0) ? run_lens[hi] : 0;
        n = l1 + l2 + 1;
        if (lo >= 0) begin
          e = find_key(val - l1);
          if (e >= 0) run_lens[e] = n;
        end
        if (hi >= 0) begin
          e = find_key(val + l2);
          if (e >= 0) run_lens[e] = n;
        end
        run_keys.push_back(val);
        run_lens.push_back(n);
        if (n > best_run) best_run = n;
      end
    end
    r.longest  = (best_run > 511) ? 9'd511 : best_run[LEN_W-1:0];
    r.overflow = drop_seen;
    if (last) begin
      run_keys.delete();
      run_lens.delete();
      best_run  = 0;
      drop_seen = 1'b0;
    end
    return r;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    run_result_t exp_r, typed_r;
    logic typed_f;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", longest_o, -1);
      end else begin
        exp_r   = pending_results.pop_front();
        typed_r = typed_results.pop_front();
        typed_f = typed_flags.pop_front();
        if (longest_o !== exp_r.longest)
          report_mismatch("longest", longest_o, exp_r.longest);
        if (overflow_o !== exp_r.overflow)
          report_mismatch("overflow", overflow_o, exp_r.overflow);
        if (typed_f && (longest_o !== typed_r.longest))
          report_mismatch("longest (table)", longest_o, typed_r.longest);
        if (typed_f && (overflow_o !== typed_r.overflow))
          report_mismatch("overflow (table)", overflow_o, typed_r.overflow);
      end
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL longest_consecutive_run_tracker_core");
      $finish;
    end
  end

  // Drive one request and wait for it to be taken; start stays high afterwards
  // until the next gap or the caller drops it
  task automatic send_request(input logic [KEY_W-1:0] val, input logic last,
                              input logic typed, input run_result_t typed_r);
    int gap;
    if (!calm_mode && ($urandom_range(0, 3) == 0)) begin
      start_i <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= val;
    last_i  <= last;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(merge_value(val, last));
    typed_results.push_back(typed_r);
    typed_flags.push_back(typed);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] random_word();
    return $urandom();
  endfunction

  initial begin
    stim_row_t   rows[$];
    run_result_t tr;
    logic [KEY_W-1:0] base, v;
    int set_len, span;

    // Extremes, wrap guard, duplicates, merges, two-neighbor join
    rows = '{
      '{32'h0000_0000, 1'b0, 1'b1, 9'd1, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b1, 9'd1, 1'b0},
      '{32'h0000_0002, 1'b0, 1'b1, 9'd1, 1'b0},
      '{32'h0000_0001, 1'b0, 1'b1, 9'd3, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b1, 9'd4, 1'b0},
      '{32'h0000_0003, 1'b1, 1'b1, 9'd5, 1'b0},
      '{32'h7FFF_FFFF, 1'b0, 1'b1, 9'd1, 1'b0},
      '{32'h8000_0000, 1'b0, 1'b1, 9'd1, 1'b0},
      '{32'h7FFF_FFFE, 1'b0, 1'b1, 9'd2, 1'b0},
      '{32'h8000_0001, 1'b0, 1'b1, 9'd2, 1'b0},
      '{32'h7FFF_FFFF, 1'b1, 1'b1, 9'd2, 1'b0},
      '{32'h5555_5555, 1'b0, 1'b0, 9'd0, 1'b0},
      '{32'hAAAA_AAAA, 1'b0, 1'b0, 9'd0, 1'b0},
      '{32'h5555_5557, 1'b0, 1'b0, 9'd0, 1'b0},
      '{32'h5555_5556, 1'b1, 1'b0, 9'd0, 1'b0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      tr.longest  = rows[i].longest;
      tr.overflow = rows[i].overflow;
      send_request(rows[i].value, rows[i].last, rows[i].check_exact, tr);
    end

    // Fill the table past capacity: overflow then clear on last
    for (int i = 0; i < TABLE_ENTRIES + 3; i++) begin
      v = (i % 2 == 0) ? 32'h1000_0000 + i : 32'hF000_0000 - i;
      send_request(v, 1'b0, 1'b0, tr);
    end
    tr.longest  = 9'd1;
    tr.overflow = 1'b1;
    send_request(32'h1234_5678, 1'b1, 1'b1, tr);

    // Hold off until every result has come back
    start_i <= 1'b0;
    wait_drained();

    // Random sets: mostly clustered values so runs form and merge
    for (int n = 0; n < RANDOM_ITEMS; ) begin
      if (n > RANDOM_ITEMS - 150) calm_mode = 1'b1;
      set_len = $urandom_range(1, 40);
      base    = random_word();
      span    = $urandom_range(2, 60);
      for (int k = 0; k < set_len; k++) begin
        case ($urandom_range(0, 9))
          0:       v = random_word();
          1:       v = ($urandom_range(0, 1)) ? KEY_MIN + $urandom_range(0, 3)
                                              : KEY_MAX - $urandom_range(0, 3);
          default: v = base + $urandom_range(0, span);
        endcase
        send_request(v, (k == set_len - 1), 1'b0, tr);
        n++;
      end
    end

    start_i <= 1'b0;
    fork
      wait_drained();
      begin
        repeat (WATCHDOG_LIMIT) @(posedge clk_i);
        timed_out = 1'b1;
      end
    join_any
    disable fork;
    if (timed_out) begin
      $display("FAIL longest_consecutive_run_tracker_core");
      $finish;
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      if (error_count == 0 && pending_results.size() == 0) begin
        $display("PASS longest_consecutive_run_tracker_core");
      end else begin
        $display("FAIL longest_consecutive_run_tracker_core");
      end
      $finish;
    end
  end

endmodule

[longest_consecutive_run_tracker_core.f]
rtl/core/lcr_pkg.sv
rtl/core/lcr_ram.sv
rtl/core/longest_consecutive_run_tracker_core.sv
tb/tb_top.sv
